FILE: hdl/lot_pkg.sv
// package with shared constants, codes and control types of the lock tracker
`timescale 1ns / 1ps
package lot_pkg;

  localparam int CPU_COUNT_DEF   = 8;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [2:0] REQ_ACQUIRE = 3'd0;
  localparam logic [2:0] REQ_RELEASE = 3'd1;
  localparam logic [2:0] REQ_GLOBAL  = 3'd2;
  localparam logic [2:0] REQ_NOTE    = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;
  localparam logic [2:0] REQ_QUERY   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_INVERSION = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_ORDER     = 3'd4;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_run;
    logic stk_rd;
    logic stk_eval;
    logic clr_run;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic clr_done;
    logic go_stack;
    logic go_scan;
    logic scan_end;
  } sts_t;

endpackage

FILE: hdl/lot_in_if.sv
// request channel interface
`timescale 1ns / 1ps
interface lot_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [2:0]  cpu_index;
  logic [7:0]  lock_level;
  logic [63:0] lock_addr;
  logic [63:0] call_site;

  modport source (output valid, req_type, cpu_index, lock_level, lock_addr, call_site,
                  input ready);
  modport sink (input valid, req_type, cpu_index, lock_level, lock_addr, call_site,
                output ready);
endinterface

FILE: hdl/lot_out_if.sv
// result channel interface
`timescale 1ns / 1ps
interface lot_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  top_level;
  logic [4:0]  held_depth;
  logic        holder_found;
  logic [2:0]  holder_cpu;
  logic [63:0] holder_site;

  modport source (output valid, status, top_level, held_depth, holder_found, holder_cpu,
                  holder_site, input ready);
  modport sink (input valid, status, top_level, held_depth, holder_found, holder_cpu,
                holder_site, output ready);
endinterface

FILE: hdl/lot_dp.sv
// datapath: level stacks, spin slot tables, scan counters and result registers
`timescale 1ns / 1ps
module lot_dp
  import lot_pkg::*;
#(
  parameter int CPU_COUNT   = CPU_COUNT_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  ctl_t         ctl,
  output sts_t         sts,
  input  logic [2:0]   in_req_type,
  input  logic [2:0]   in_cpu_index,
  input  logic [7:0]   in_lock_level,
  input  logic [63:0]  in_lock_addr,
  input  logic [63:0]  in_call_site,
  output logic [2:0]   out_status,
  output logic [7:0]   out_top_level,
  output logic [4:0]   out_held_depth,
  output logic         out_holder_found,
  output logic [2:0]   out_holder_cpu,
  output logic [63:0]  out_holder_site
);

  localparam int TOTAL = CPU_COUNT * STACK_DEPTH;
  localparam int TW    = $clog2(TOTAL);
  localparam int CW    = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int SW    = $clog2(STACK_DEPTH);
  localparam int DW    = $clog2(STACK_DEPTH + 1);

  logic [7:0]    stack_mem [TOTAL];
  logic [63:0]   addr_mem  [TOTAL];
  logic [63:0]   site_mem  [TOTAL];
  logic [DW-1:0] depth_r   [CPU_COUNT];

  logic [2:0]    req_r;
  logic [CW-1:0] cpu_r;
  logic          cpu_ok_r;
  logic [7:0]    lvl_r;
  logic [63:0]   addr_r;
  logic [63:0]   site_r;

  logic [2:0]    res_status_r;
  logic [7:0]    res_top_r;
  logic          res_found_r;
  logic [CW-1:0] res_cpu_r;
  logic [63:0]   res_site_r;

  logic [7:0]    stk_q_r;
  logic [TW-1:0] clr_idx_r;

  logic          issue_act_r;
  logic          scan_all_r;
  logic [TW-1:0] issue_idx_r;
  logic [CW-1:0] issue_cpu_r;
  logic [SW-1:0] issue_slot_r;
  logic          rdv_r;
  logic          rd_last_r;
  logic [TW-1:0] rd_idx_r;
  logic [CW-1:0] rd_cpu_r;
  logic [63:0]   addr_q_r;
  logic [63:0]   site_q_r;

  logic [TW-1:0] base;
  logic [DW-1:0] d;
  logic          issue_last;
  logic          hit;
  logic          slot_we;
  logic [TW-1:0] slot_wa;
  logic [63:0]   slot_wa_d;
  logic [63:0]   slot_ws_d;
  logic          stk_we;
  logic          acq_ok;
  logic          rel_ok;

  assign base = TW'(cpu_r) * TW'(STACK_DEPTH);
  assign d    = depth_r[cpu_r];

  assign issue_last = (issue_slot_r == SW'(STACK_DEPTH - 1)) &&
                      (!scan_all_r || issue_cpu_r == CW'(CPU_COUNT - 1));

  assign hit = rdv_r && ((req_r == REQ_NOTE) ? (addr_q_r == 64'd0) : (addr_q_r == addr_r));

  assign acq_ok = (d < DW'(STACK_DEPTH)) && !((d != '0) && (stk_q_r > lvl_r));
  assign rel_ok = (d != '0) && (stk_q_r == lvl_r);
  assign stk_we = ctl.stk_eval && (req_r == REQ_ACQUIRE) && acq_ok;

  assign sts.clr_done = (clr_idx_r == TW'(TOTAL - 1));
  assign sts.go_stack = cpu_ok_r && req_r != REQ_QUERY &&
                        (req_r == REQ_ACQUIRE || req_r == REQ_RELEASE || req_r == REQ_GLOBAL);
  assign sts.go_scan  = (addr_r != 64'd0) &&
                        (req_r == REQ_QUERY ||
                         (cpu_ok_r && (req_r == REQ_NOTE || req_r == REQ_CLEAR)));
  assign sts.scan_end = rdv_r && (hit || rd_last_r);

  always_comb begin
    slot_we   = 1'b0;
    slot_wa   = rd_idx_r;
    slot_wa_d = 64'd0;
    slot_ws_d = 64'd0;
    if (ctl.clr_run) begin
      slot_we = 1'b1;
      slot_wa = clr_idx_r;
    end else if (ctl.scan_run && hit && req_r == REQ_NOTE) begin
      slot_we   = 1'b1;
      slot_wa_d = addr_r;
      slot_ws_d = site_r;
    end else if (ctl.scan_run && hit && req_r == REQ_CLEAR) begin
      slot_we = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (slot_we) begin
      addr_mem[slot_wa] <= slot_wa_d;
      site_mem[slot_wa] <= slot_ws_d;
    end
    if (ctl.scan_run && issue_act_r) begin
      addr_q_r <= addr_mem[issue_idx_r];
      site_q_r <= site_mem[issue_idx_r];
    end
    if (stk_we) begin
      stack_mem[base + TW'(d)] <= lvl_r;
    end
    if (ctl.stk_rd) begin
      stk_q_r <= stack_mem[base + TW'(d) - TW'(1)];
    end
  end

  // control counters and depths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      issue_act_r <= 1'b0;
      rdv_r       <= 1'b0;
      for (int c = 0; c < CPU_COUNT; c++) begin
        depth_r[c] <= '0;
      end
    end else begin
      if (ctl.clr_run && !sts.clr_done) begin
        clr_idx_r <= clr_idx_r + TW'(1);
      end
      if (ctl.scan_start) begin
        issue_act_r  <= 1'b1;
        rdv_r        <= 1'b0;
        scan_all_r   <= (req_r == REQ_QUERY);
        issue_idx_r  <= (req_r == REQ_QUERY) ? '0 : base;
        issue_cpu_r  <= (req_r == REQ_QUERY) ? '0 : cpu_r;
        issue_slot_r <= '0;
      end else if (ctl.scan_run) begin
        rdv_r <= issue_act_r;
        if (issue_act_r) begin
          rd_idx_r    <= issue_idx_r;
          rd_cpu_r    <= issue_cpu_r;
          rd_last_r   <= issue_last;
          issue_idx_r <= issue_idx_r + TW'(1);
          if (issue_last) begin
            issue_act_r <= 1'b0;
          end
          if (issue_slot_r == SW'(STACK_DEPTH - 1)) begin
            issue_slot_r <= '0;
            issue_cpu_r  <= issue_cpu_r + CW'(1);
          end else begin
            issue_slot_r <= issue_slot_r + SW'(1);
          end
        end
      end
      if (stk_we) begin
        depth_r[cpu_r] <= d + DW'(1);
      end else if (ctl.stk_eval && req_r == REQ_RELEASE && rel_ok) begin
        depth_r[cpu_r] <= d - DW'(1);
      end
    end
  end

  // request capture and result registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_r        <= in_req_type;
      cpu_r        <= CW'(in_cpu_index);
      cpu_ok_r     <= ({29'd0, in_cpu_index} < 32'(CPU_COUNT));
      lvl_r        <= in_lock_level;
      addr_r       <= in_lock_addr;
      site_r       <= in_call_site;
      res_status_r <= ST_OK;
      res_top_r    <= 8'd0;
      res_found_r  <= 1'b0;
      res_cpu_r    <= '0;
      res_site_r   <= 64'd0;
    end
    if (ctl.stk_eval) begin
      case (req_r)
        REQ_ACQUIRE: begin
          if (d >= DW'(STACK_DEPTH)) begin
            res_status_r <= ST_OVERFLOW;
            res_top_r    <= stk_q_r;
          end else if (d != '0 && stk_q_r > lvl_r) begin
            res_status_r <= ST_INVERSION;
            res_top_r    <= stk_q_r;
          end
        end
        REQ_RELEASE: begin
          if (d == '0) begin
            res_status_r <= ST_EMPTY;
          end else if (stk_q_r != lvl_r) begin
            res_status_r <= ST_ORDER;
            res_top_r    <= stk_q_r;
          end
        end
        REQ_GLOBAL: begin
          if (d != '0 && stk_q_r > lvl_r) begin
            res_status_r <= ST_INVERSION;
            res_top_r    <= stk_q_r;
          end
        end
        default: begin
        end
      endcase
    end
    if (ctl.scan_run && hit && req_r == REQ_QUERY) begin
      res_found_r <= 1'b1;
      res_cpu_r   <= rd_cpu_r;
      res_site_r  <= site_q_r;
    end
    if (ctl.out_load) begin
      out_status       <= res_status_r;
      out_top_level    <= res_top_r;
      out_held_depth   <= cpu_ok_r ? 5'(d) : 5'd0;
      out_holder_found <= res_found_r;
      out_holder_cpu   <= 3'(res_cpu_r);
      out_holder_site  <= res_site_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    stk_we |-> (d < DW'(STACK_DEPTH)))
    else $error("push onto full stack");

  assert property (@(posedge clk) disable iff (!rst_n)
    cpu_ok_r |-> (d <= DW'(STACK_DEPTH)))
    else $error("stack depth beyond limit");

  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.scan_run && rdv_r && !$past(ctl.scan_start)) |-> $past(issue_act_r))
    else $error("slot data valid without a read");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.clr_run && (ctl.scan_run || ctl.stk_eval)))
    else $error("clearing pass overlaps a request");

endmodule

FILE: hdl/lot_ctrl.sv
// controller state machine and output handshake
`timescale 1ns / 1ps
module lot_ctrl
  import lot_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_STK_RD, S_STK_EV, S_SCAN, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    case (state_r)
      S_CLEAR: begin
        ctl.clr_run = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.go_stack) begin
          state_nxt = S_STK_RD;
        end else if (sts.go_scan) begin
          ctl.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_STK_RD: begin
        ctl.stk_rd = 1'b1;
        state_nxt  = S_STK_EV;
      end
      S_STK_EV: begin
        ctl.stk_eval = 1'b1;
        state_nxt    = S_FIN;
      end
      S_SCAN: begin
        ctl.scan_run = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> out_valid_r)
    else $error("result load without valid");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted transaction not decoded");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STK_RD) |=> (state_r == S_STK_EV))
    else $error("stack read not followed by evaluation");

endmodule

FILE: hdl/lock_order_and_holder_tracker.sv
// top level of the lock order and spinlock holder tracker
// steps: acquire, release and global acquire with a valid CPU index pass decode, stack read and
// stack evaluation before the result load, other requests that skip the slot scan go from decode
// to the load; spin note and clear scan the CPU's slots, holder query all, one slot read a cycle
// throughput: one transaction at a time; a pending result waits in the output register
// reset: depths cleared at once, then a clearing pass zeroes every slot table entry
`timescale 1ns / 1ps
module lock_order_and_holder_tracker
  import lot_pkg::*;
#(
  parameter int CPU_COUNT   = CPU_COUNT_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  lot_in_if.sink    in_ch,
  lot_out_if.source out_ch
);

  ctl_t ctl;
  sts_t sts;

  lot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  lot_dp #(
    .CPU_COUNT   (CPU_COUNT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_req_type      (in_ch.req_type),
    .in_cpu_index     (in_ch.cpu_index),
    .in_lock_level    (in_ch.lock_level),
    .in_lock_addr     (in_ch.lock_addr),
    .in_call_site     (in_ch.call_site),
    .out_status       (out_ch.status),
    .out_top_level    (out_ch.top_level),
    .out_held_depth   (out_ch.held_depth),
    .out_holder_found (out_ch.holder_found),
    .out_holder_cpu   (out_ch.holder_cpu),
    .out_holder_site  (out_ch.holder_site)
  );

endmodule
